>>> design/bhpq_pkg.sv
// Shared types, codes and defaults for the binary heap priority queue.
`default_nettype none
package bhpq_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int COUNT_W       = 11;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 144;
    localparam int CODE_W        = 2;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_PUSH_INIT,
        DP_POP_INIT,
        DP_CLEAR,
        DP_UP_READ,
        DP_UP_MOVE,
        DP_UP_PLACE,
        DP_POP_RDMV,
        DP_LOAD_MV,
        DP_DN_READ,
        DP_DN_MOVE,
        DP_DN_PLACE,
        DP_RESULT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHK,
        S_UP_CMP,
        S_POP_CHK,
        S_POP_LDMV,
        S_DN_READ,
        S_DN_CMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic at_root;
        logic up_better;
        logic dn_stay;
        logic count_zero;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> design/bhpq_dp.sv
// Heap datapath: entry store, sift registers, comparators and result register.
`default_nettype none
module bhpq_dp #(
    parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bhpq_pkg::t_dp_op                   i_op,
    output bhpq_pkg::t_dp_stat                      o_stat,
    input  wire logic [bhpq_pkg::CODE_W-1:0]        i_req,
    input  wire logic [bhpq_pkg::FIELD_W-1:0]       i_key,
    input  wire logic [bhpq_pkg::FIELD_W-1:0]       i_payload,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_data,
    output logic      [bhpq_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic      [bhpq_pkg::CODE_W-1:0]        o_tuser
);
    import bhpq_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = IW + 2;
    localparam int EW  = KEY_WIDTH + FIELD_W;

    function automatic logic better(input logic signed [KEY_WIDTH-1:0] a,
                                    input logic signed [KEY_WIDTH-1:0] b,
                                    input logic mm);
        return mm ? (a < b) : (a > b);
    endfunction

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rd_a, r_rd_b;

    logic [CW-1:0]              r_count;
    logic                       r_min_mode;
    logic [IW-1:0]              r_at;
    logic [EW-1:0]              r_mv;
    logic [EW-1:0]              r_root;
    t_req                       r_req;
    t_status                    r_status;
    logic signed [FIELD_W-1:0]  r_pk;
    logic [FIELD_W-1:0]         r_pp;
    logic [OUT_TDATA_W-1:0]     r_tdata;
    logic [CODE_W-1:0]          r_tuser;

    logic [IW-1:0]  up_idx;
    logic [CIW-1:0] l_idx, r_idx, n_ext;
    logic           l_ok, r_ok, l_better, r_better;
    logic signed [KEY_WIDTH-1:0] mv_key, a_key, b_key, cur_key;
    logic [IW-1:0]  rd_addr_a, rd_addr_b;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;
    logic [CW+10:0] count_wide;
    logic signed [FIELD_W-1:0] top_key_x;
    logic [FIELD_W-1:0]        top_pay_x;
    logic                      top_valid;

    assign up_idx   = (r_at - 1'b1) >> 1;
    assign l_idx    = {1'b0, r_at, 1'b1};
    assign r_idx    = l_idx + 1'b1;
    assign n_ext    = CIW'(r_count);
    assign l_ok     = l_idx < n_ext;
    assign r_ok     = r_idx < n_ext;
    assign mv_key   = $signed(r_mv[KEY_WIDTH-1:0]);
    assign a_key    = $signed(r_rd_a[KEY_WIDTH-1:0]);
    assign b_key    = $signed(r_rd_b[KEY_WIDTH-1:0]);
    assign l_better = l_ok && better(a_key, mv_key, r_min_mode);
    assign cur_key  = l_better ? a_key : mv_key;
    assign r_better = r_ok && better(b_key, cur_key, r_min_mode);

    assign o_stat.req        = r_req;
    assign o_stat.full       = (r_count == CW'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.at_root    = (r_at == '0);
    assign o_stat.up_better  = better(mv_key, a_key, r_min_mode);
    assign o_stat.dn_stay    = !l_better && !r_better;
    assign o_stat.count_zero = (r_count == '0);

    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_at;
        wr_data   = r_mv;
        case (i_op)
            DP_UP_READ:  rd_addr_a = up_idx;
            DP_POP_RDMV: rd_addr_a = r_count[IW-1:0];
            DP_DN_READ: begin
                rd_addr_a = l_idx[IW-1:0];
                rd_addr_b = r_idx[IW-1:0];
            end
            DP_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_a;
            end
            DP_DN_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_better ? r_rd_b : r_rd_a;
            end
            DP_UP_PLACE, DP_DN_PLACE: wr_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // keep a copy of slot zero so the top is known without a read
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == '0) begin
            r_root <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_min_mode <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_min_mode <= i_cfg_data;
            end
            case (i_op)
                DP_PUSH_INIT: r_count <= r_count + 1'b1;
                DP_POP_INIT:  r_count <= r_count - 1'b1;
                DP_CLEAR:     r_count <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_req    <= t_req'(i_req);
                r_mv     <= {i_payload, i_key[KEY_WIDTH-1:0]};
                r_status <= ST_OK;
                r_pk     <= '0;
                r_pp     <= '0;
            end
            DP_SET_FULL:  r_status <= ST_FULL;
            DP_SET_EMPTY: r_status <= ST_EMPTY;
            DP_PUSH_INIT: r_at <= r_count[IW-1:0];
            DP_POP_INIT: begin
                r_pk <= FIELD_W'($signed(r_root[KEY_WIDTH-1:0]));
                r_pp <= r_root[EW-1:KEY_WIDTH];
            end
            DP_UP_MOVE: r_at <= up_idx;
            DP_LOAD_MV: begin
                r_mv <= r_rd_a;
                r_at <= '0;
            end
            DP_DN_MOVE: r_at <= r_better ? r_idx[IW-1:0] : l_idx[IW-1:0];
            DP_RESULT: begin
                r_tdata <= {4'b0, count_wide[COUNT_W-1:0], top_pay_x, top_key_x,
                            top_valid, r_pp, r_pk};
                r_tuser <= r_status;
            end
            default: ;
        endcase
    end

    assign count_wide = (CW + COUNT_W)'(r_count);
    assign top_valid  = (r_count != '0);
    assign top_key_x  = top_valid ? FIELD_W'($signed(r_root[KEY_WIDTH-1:0])) : '0;
    assign top_pay_x  = top_valid ? r_root[EW-1:KEY_WIDTH] : '0;

    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule
`default_nettype wire

>>> design/bhpq_ctrl.sv
// Heap controller: request decode, sift sequencing and output handshake.
`default_nettype none
module bhpq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire bhpq_pkg::t_dp_stat   i_stat,
    output bhpq_pkg::t_dp_op          o_op
);
    import bhpq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = DP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_PUSH: begin
                        if (i_stat.full) begin
                            o_op    = DP_SET_FULL;
                            n_state = S_FINISH;
                        end else begin
                            o_op    = DP_PUSH_INIT;
                            n_state = S_UP_CHK;
                        end
                    end
                    REQ_POP: begin
                        if (i_stat.empty) begin
                            o_op    = DP_SET_EMPTY;
                            n_state = S_FINISH;
                        end else begin
                            o_op    = DP_POP_INIT;
                            n_state = S_POP_CHK;
                        end
                    end
                    REQ_CLEAR: begin
                        o_op    = DP_CLEAR;
                        n_state = S_FINISH;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_op    = DP_UP_PLACE;
                    n_state = S_FINISH;
                end else begin
                    o_op    = DP_UP_READ;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_better) begin
                    o_op    = DP_UP_MOVE;
                    n_state = S_UP_CHK;
                end else begin
                    o_op    = DP_UP_PLACE;
                    n_state = S_FINISH;
                end
            end
            S_POP_CHK: begin
                // last entry gone: nothing to sink
                if (i_stat.count_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_op    = DP_POP_RDMV;
                    n_state = S_POP_LDMV;
                end
            end
            S_POP_LDMV: begin
                o_op    = DP_LOAD_MV;
                n_state = S_DN_READ;
            end
            S_DN_READ: begin
                o_op    = DP_DN_READ;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_stay) begin
                    o_op    = DP_DN_PLACE;
                    n_state = S_FINISH;
                end else begin
                    o_op    = DP_DN_MOVE;
                    n_state = S_DN_READ;
                end
            end
            S_FINISH: begin
                // hold until the previous result beat has been taken
                if (!r_out_valid || i_out_ready) begin
                    o_op        = DP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> design/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: stream ports, controller and datapath.
// Push sifts the new entry up; pop moves the last entry to the root and sinks it.
// A clear, a no-op, a push when full and a pop when empty move no entry.
// Flow: one request at a time, none taken while a sift runs;
//   the next request is taken while a result beat waits; a second result holds until taken.
// Reset: synchronous active low; empties the queue and selects min order. Store not cleared.
`default_nettype none
module binary_heap_priority_queue #(
    parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // key [31:0], payload [63:32]
    input  wire logic [bhpq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type [1:0]
    input  wire logic [bhpq_pkg::CODE_W-1:0]       s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // popped_key [31:0], popped_payload [63:32], top_valid [64], top_key [96:65],
    // top_payload [128:97], entry_count [139:129], zero [143:140]
    output logic      [bhpq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic      [bhpq_pkg::CODE_W-1:0]       m_axis_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    // min_mode
    input  wire logic                              i_cfg_data
);
    import bhpq_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    bhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_op        (op)
    );

    bhpq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_req       (s_axis_tuser),
        .i_key       (s_axis_tdata[FIELD_W-1:0]),
        .i_payload   (s_axis_tdata[IN_TDATA_W-1:FIELD_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule
`default_nettype wire
